>>> rtl/ansi_csi_key_decoder_assert.svh
// assertion macros used by the checker file
`ifndef ANSI_CSI_KEY_DECODER_ASSERT_SVH
`define ANSI_CSI_KEY_DECODER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ACSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("acsi assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define ACSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("acsi assertion failed");

`endif

>>> rtl/acsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acsi_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // parse phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  // byte codes
  localparam logic [7:0] CH_ESC       = 8'h1b;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_FINAL_LO  = 8'h40;
  localparam logic [7:0] CH_FINAL_HI  = 8'h7e;
  localparam logic [7:0] CH_PARAM_LO  = 8'h20;
  localparam logic [7:0] CH_PARAM_HI  = 8'h3f;
  localparam logic [7:0] CH_TILDE     = 8'h7e;
  localparam logic [7:0] CH_A         = 8'h41;
  localparam logic [7:0] CH_B         = 8'h42;
  localparam logic [7:0] CH_C         = 8'h43;
  localparam logic [7:0] CH_D         = 8'h44;
  localparam logic [7:0] CH_H         = 8'h48;
  localparam logic [7:0] CH_F         = 8'h46;
  localparam logic [7:0] CH_DIGIT_1   = 8'h31;
  localparam logic [7:0] CH_DIGIT_3   = 8'h33;
  localparam logic [7:0] CH_DIGIT_4   = 8'h34;

  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_UP     = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_RIGHT  = 3'd3,
    KEY_LEFT   = 3'd4,
    KEY_HOME   = 3'd5,
    KEY_END    = 3'd6,
    KEY_DELETE = 3'd7
  } key_event_e;

  // sequence context handed to the final-byte decoder
  typedef struct packed {
    logic no_params;
    logic one_param;
    logic overflow;
  } seq_ctx_t;

endpackage

`default_nettype wire

>>> rtl/acsi_final_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// maps a final byte plus the sequence context to a key event
module acsi_final_decode (
  input  wire acsi_pkg::seq_ctx_t   ctx_i,
  input  wire logic [7:0]           final_byte_i,
  input  wire logic [7:0]           first_param_i,
  output acsi_pkg::key_event_e      key_event_o
);

  always_comb begin
    key_event_o = acsi_pkg::KEY_NONE;
    if (ctx_i.overflow) begin
      key_event_o = acsi_pkg::KEY_NONE;
    end else if (ctx_i.no_params) begin
      unique case (final_byte_i)
        acsi_pkg::CH_A: key_event_o = acsi_pkg::KEY_UP;
        acsi_pkg::CH_B: key_event_o = acsi_pkg::KEY_DOWN;
        acsi_pkg::CH_C: key_event_o = acsi_pkg::KEY_RIGHT;
        acsi_pkg::CH_D: key_event_o = acsi_pkg::KEY_LEFT;
        acsi_pkg::CH_H: key_event_o = acsi_pkg::KEY_HOME;
        acsi_pkg::CH_F: key_event_o = acsi_pkg::KEY_END;
        default:        key_event_o = acsi_pkg::KEY_NONE;
      endcase
    end else if (ctx_i.one_param && (final_byte_i == acsi_pkg::CH_TILDE)) begin
      // vt-style "ESC [ n ~" keys
      unique case (first_param_i)
        acsi_pkg::CH_DIGIT_1: key_event_o = acsi_pkg::KEY_HOME;
        acsi_pkg::CH_DIGIT_3: key_event_o = acsi_pkg::KEY_DELETE;
        acsi_pkg::CH_DIGIT_4: key_event_o = acsi_pkg::KEY_END;
        default:              key_event_o = acsi_pkg::KEY_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ansi_csi_key_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// ANSI escape / CSI key decoder. Terminal bytes enter on the slave stream one per
// transfer and every byte yields exactly one result transfer on the master stream,
// in order. A result tells which key (if any) the byte completed, whether the byte
// was part of an escape sequence and must be dropped from the text path, and
// whether a sequence is still open afterwards. Recognized keys: ESC [ A/B/C/D
// (arrows), ESC [ H / F (home / end) and ESC [ 1~ / 3~ / 4~ (home / delete / end).
// Parameter bytes beyond PARAM_LIMIT mark the sequence overflowed and it then
// ends without an event; ESC inside a sequence restarts it, and a control or
// high byte inside a CSI aborts it. Throughput is one byte per clock: the parser
// state update is a single short compare-and-select step that runs in the cycle
// the byte is taken, and the result is written into the output register at the end of that cycle.
// A new byte is taken while a result waits whenever the master side takes that
// result in the same cycle; the only stall source is the downstream tready.
module ansi_csi_key_decoder #(
  parameter int unsigned PARAM_LIMIT = 8   // max stored parameter bytes, 1..64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  // slave stream: terminal bytes
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,    // [7:0] rx_byte

  // master stream: decode results
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o     // [2:0] key_event, [3] byte_consumed,
                                             // [4] sequence_open, [7:5] zero
);

  // count must hold PARAM_LIMIT itself
  localparam int unsigned CntW = $clog2(PARAM_LIMIT + 1);

  // parser state
  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] param_cnt_q, param_cnt_d;
  logic            param_ovf_q, param_ovf_d;
  logic [7:0]      first_param_q, first_param_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_data_q, out_data_d;

  logic in_xfer;
  logic out_xfer;

  acsi_pkg::seq_ctx_t   seq_ctx;
  acsi_pkg::key_event_e final_event;
  acsi_pkg::key_event_e key_event;
  logic                 byte_used;
  logic [7:0]           rx_byte;

  assign rx_byte  = s_axis_tdata_i;
  assign out_xfer = out_valid_q & m_axis_tready_i;
  // take a byte whenever the output slot is free or being emptied this cycle
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_xfer  = s_axis_tvalid_i & s_axis_tready_o;

  assign seq_ctx.no_params = (param_cnt_q == '0);
  assign seq_ctx.one_param = (param_cnt_q == CntW'(1));
  assign seq_ctx.overflow  = param_ovf_q;

  acsi_final_decode u_final_decode (
    .ctx_i         (seq_ctx),
    .final_byte_i  (rx_byte),
    .first_param_i (first_param_q),
    .key_event_o   (final_event)
  );

  // next-state and result for the byte on the input
  always_comb begin
    phase_d       = phase_q;
    param_cnt_d   = param_cnt_q;
    param_ovf_d   = param_ovf_q;
    first_param_d = first_param_q;
    key_event     = acsi_pkg::KEY_NONE;
    byte_used     = 1'b1;

    unique case (phase_q)
      acsi_pkg::PH_IDLE: begin
        if (rx_byte == acsi_pkg::CH_ESC) begin
          phase_d = acsi_pkg::PH_ESC;
        end else begin
          byte_used = 1'b0;   // plain text passes through
        end
      end
      acsi_pkg::PH_ESC: begin
        if (rx_byte == acsi_pkg::CH_LBRACKET) begin
          phase_d     = acsi_pkg::PH_CSI;
          param_cnt_d = '0;
          param_ovf_d = 1'b0;
        end else if (rx_byte != acsi_pkg::CH_ESC) begin
          // not a CSI after all, hand the byte on
          phase_d     = acsi_pkg::PH_IDLE;
          param_cnt_d = '0;
          param_ovf_d = 1'b0;
          byte_used   = 1'b0;
        end
      end
      default: begin
        // CSI phase (the unused code behaves the same)
        priority if (rx_byte == acsi_pkg::CH_ESC) begin
          phase_d     = acsi_pkg::PH_ESC;
          param_cnt_d = '0;
          param_ovf_d = 1'b0;
        end else if ((rx_byte >= acsi_pkg::CH_FINAL_LO) &&
                     (rx_byte <= acsi_pkg::CH_FINAL_HI)) begin
          key_event   = final_event;
          phase_d     = acsi_pkg::PH_IDLE;
          param_cnt_d = '0;
          param_ovf_d = 1'b0;
        end else if ((rx_byte < acsi_pkg::CH_PARAM_LO) ||
                     (rx_byte > acsi_pkg::CH_PARAM_HI)) begin
          // illegal byte aborts silently
          phase_d     = acsi_pkg::PH_IDLE;
          param_cnt_d = '0;
          param_ovf_d = 1'b0;
        end else if (param_cnt_q < CntW'(PARAM_LIMIT)) begin
          if (param_cnt_q == '0) begin
            first_param_d = rx_byte;
          end
          param_cnt_d = param_cnt_q + CntW'(1);
        end else begin
          param_ovf_d = 1'b1;
        end
      end
    endcase

    out_data_d = {3'b000, (phase_d != acsi_pkg::PH_IDLE), byte_used, key_event};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= acsi_pkg::PH_IDLE;
      param_cnt_q <= '0;
      param_ovf_q <= 1'b0;
    end else if (in_xfer) begin
      phase_q     <= phase_d;
      param_cnt_q <= param_cnt_d;
      param_ovf_q <= param_ovf_d;
    end
  end

  // first parameter byte is only read once written in the same sequence
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      first_param_q <= first_param_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/acsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ansi_csi_key_decoder_assert.svh"

// port-level checks of the key decoder
module acsi_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [7:0] s_axis_tdata_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  logic key_seen;
  logic res_used;
  logic res_open;
  logic esc_taken;
  logic out_stall;

  assign res_used  = m_axis_tdata_o[3];
  assign res_open  = m_axis_tdata_o[4];
  assign key_seen  = m_axis_tvalid_o && (m_axis_tdata_o[2:0] != acsi_pkg::KEY_NONE);
  assign esc_taken = s_axis_tvalid_i && s_axis_tready_o &&
                     (s_axis_tdata_i == acsi_pkg::CH_ESC);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a key ends its sequence and swallows its final byte
  `ACSI_ASSERT_NOW(a_key_consumed, clk_i, rst_ni, key_seen, res_used && !res_open)

  // a byte handed on never leaves a sequence open
  `ACSI_ASSERT_NOW(a_pass_closes, clk_i, rst_ni, m_axis_tvalid_o && !res_used, !res_open)

  // input side never blocks while the output slot is empty
  `ACSI_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)

  // an accepted ESC is always swallowed and leaves a sequence open
  `ACSI_ASSERT_NEXT(a_esc_opens, clk_i, rst_ni, esc_taken, m_axis_tvalid_o && res_used && res_open)

  // stalled result holds
  `ACSI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind ansi_csi_key_decoder acsi_checker u_acsi_checker (.*);

`default_nettype wire
